/* design/mjdf_pkg.sv */
// -----------------------------------------------------------------------------
// mjdf_pkg
// Shared types, character codes and pattern tables of the multipart deframer.
// -----------------------------------------------------------------------------
package mjdf_pkg;

   localparam int unsigned LEN_BITS_DEF = 24;

   localparam int unsigned BND_BITS = 4;
   localparam int unsigned KEY_BITS = 4;
   localparam int unsigned END_BITS = 2;

   // last index of each pattern
   localparam logic [BND_BITS-1:0] BND_LAST = 4'd8;
   localparam logic [KEY_BITS-1:0] KEY_LAST = 4'd15;
   localparam logic [END_BITS-1:0] END_LAST = 2'd3;

   localparam logic [BND_BITS-1:0] BND_ONE = 4'd1;
   localparam logic [BND_BITS-1:0] BND_TWO = 4'd2;
   localparam logic [KEY_BITS-1:0] KEY_ONE = 4'd1;
   localparam logic [END_BITS-1:0] END_ONE = 2'd1;

   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_VT    = 8'h0B;
   localparam logic [7:0] CHR_FF    = 8'h0C;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_DASH  = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_C_UP  = 8'h43;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'b001,
      PH_HEADER  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      NP_NONE   = 4'b0001,
      NP_SKIP   = 4'b0010,
      NP_DIGITS = 4'b0100,
      NP_DONE   = 4'b1000
   } num_phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] frame_byte;
      logic       frame_last;
   } result_type;

   // "--frame\r\n"
   function automatic logic [7:0] bnd_char(input logic [BND_BITS-1:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h2D;
         4'd1:    ch = 8'h2D;
         4'd2:    ch = 8'h66;
         4'd3:    ch = 8'h72;
         4'd4:    ch = 8'h61;
         4'd5:    ch = 8'h6D;
         4'd6:    ch = 8'h65;
         4'd7:    ch = 8'h0D;
         4'd8:    ch = 8'h0A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "Content-Length: "
   function automatic logic [7:0] key_char(input logic [KEY_BITS-1:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h43;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6E;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2D;
         4'd8:    ch = 8'h4C;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6E;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         4'd14:   ch = 8'h3A;
         4'd15:   ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "\r\n\r\n"
   function automatic logic [7:0] end_char(input logic [END_BITS-1:0] idx);
      return idx[0] ? CHR_LF : CHR_CR;
   endfunction

   function automatic logic is_ws(input logic [7:0] ch);
      return (ch == CHR_SPACE) || (ch == CHR_TAB) || (ch == CHR_CR) ||
             (ch == CHR_LF) || (ch == CHR_VT) || (ch == CHR_FF);
   endfunction

endpackage

/* design/mjdf_chan_if.sv */
// -----------------------------------------------------------------------------
// mjdf channel interfaces
// Valid/ready channels for stream bytes in and frame bytes out.
// -----------------------------------------------------------------------------
interface mjdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface mjdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

/* design/mjdf_input_reg.sv */
// -----------------------------------------------------------------------------
// mjdf_input_reg
// Input register: holds one stream byte until the parser consumes it.
// -----------------------------------------------------------------------------
module mjdf_input_reg (
   input  logic               clock,
   input  logic               reset,
   mjdf_req_if.sink           req_chan,
   input  logic               take,
   output mjdf_pkg::item_type item
);
   import mjdf_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_chan.in_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

   a_hold_unconsumed: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !take |=> valid_ff && $stable(data_ff))
      else $error("input register lost or changed an unconsumed byte");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      valid_ff && take && !accept |=> !valid_ff)
      else $error("consumed byte still marked valid");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> req_chan.ready)
      else $error("empty input register not ready");

endmodule

/* design/mjdf_step.sv */
// -----------------------------------------------------------------------------
// mjdf_step
// Parser state and per-byte update: boundary hunt, header scan, payload count.
// -----------------------------------------------------------------------------
module mjdf_step #(
   parameter int unsigned LEN_BITS = mjdf_pkg::LEN_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mjdf_pkg::item_type   item,
   input  logic                 take,
   output mjdf_pkg::result_type result
);
   import mjdf_pkg::*;

   localparam int unsigned ACC_BITS = LEN_BITS + 4;
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0] LEN_ONE = {{(LEN_BITS-1){1'b0}}, 1'b1};

   phase_type           phase_ff, phase_in;
   num_phase_type       num_ff, num_in;
   logic [BND_BITS-1:0] bnd_ff, bnd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [END_BITS-1:0] end_ff, end_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [LEN_BITS-1:0] left_ff, left_in;

   logic                fire;
   logic [7:0]          ch;
   logic                digit;
   logic [3:0]          digit_val;
   logic [ACC_BITS-1:0] acc;
   logic [LEN_BITS-1:0] len_digit;
   logic                last;

   assign fire      = item.valid && take;
   assign ch        = item.data;
   assign digit     = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
   assign digit_val = 4'(ch - CHR_ZERO);

   // len * 10 + digit, saturating
   assign acc = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0} +
                {{LEN_BITS{1'b0}}, digit_val};
   assign len_digit = (acc > {4'b0000, LEN_MAX}) ? LEN_MAX : acc[LEN_BITS-1:0];

   assign last = (left_ff[LEN_BITS-1:1] == '0);

   always_comb begin
      phase_in = phase_ff;
      num_in   = num_ff;
      bnd_in   = bnd_ff;
      key_in   = key_ff;
      end_in   = end_ff;
      len_in   = len_ff;
      left_in  = left_ff;
      result   = '0;
      if (fire) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               result.valid      = 1'b1;
               result.frame_byte = ch;
               result.frame_last = last;
               left_in = (left_ff == '0) ? left_ff : left_ff - LEN_ONE;
               if (last) begin
                  phase_in = PH_HUNT;
                  bnd_in   = '0;
               end
            end
            PH_HEADER: begin
               case (num_ff)
                  NP_NONE: begin
                     if (ch == key_char(key_ff)) begin
                        if (key_ff == KEY_LAST) begin
                           num_in = NP_SKIP;
                        end else begin
                           key_in = key_ff + KEY_ONE;
                        end
                     end else begin
                        key_in = (ch == CHR_C_UP) ? KEY_ONE : '0;
                     end
                  end
                  NP_SKIP: begin
                     if (digit) begin
                        num_in = NP_DIGITS;
                        len_in = len_digit;
                     end else if (!is_ws(ch)) begin
                        num_in = NP_DONE;
                     end
                  end
                  NP_DIGITS: begin
                     if (digit) begin
                        len_in = len_digit;
                     end else begin
                        num_in = NP_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
               if (ch == end_char(end_ff)) begin
                  if (end_ff == END_LAST) begin
                     // blank line seen: zero length drops the part
                     if (len_in == '0) begin
                        phase_in = PH_HUNT;
                        bnd_in   = '0;
                     end else begin
                        phase_in = PH_PAYLOAD;
                        left_in  = len_in;
                     end
                  end else begin
                     end_in = end_ff + END_ONE;
                  end
               end else begin
                  end_in = (ch == CHR_CR) ? END_ONE : '0;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (ch == bnd_char(bnd_ff)) begin
                  if (bnd_ff == BND_LAST) begin
                     bnd_in   = '0;
                     phase_in = PH_HEADER;
                     end_in   = '0;
                     key_in   = '0;
                     num_in   = NP_NONE;
                     len_in   = '0;
                  end else begin
                     bnd_in = bnd_ff + BND_ONE;
                  end
               end else if (ch == CHR_DASH) begin
                  // extra dashes keep the "--" prefix matched
                  bnd_in = (bnd_ff == BND_TWO) ? BND_TWO : BND_ONE;
               end else begin
                  bnd_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         num_ff   <= NP_NONE;
         bnd_ff   <= '0;
         key_ff   <= '0;
         end_ff   <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         bnd_ff   <= bnd_in;
         key_ff   <= key_in;
         end_ff   <= end_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
      end
   end

   a_payload_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_last_to_hunt: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.frame_last |=> phase_ff == PH_HUNT && bnd_ff == '0)
      else $error("last frame byte did not return to hunting");

   a_result_from_payload: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> phase_ff == PH_PAYLOAD && fire)
      else $error("result produced outside payload");

   a_bnd_range: assert property (@(posedge clock) disable iff (reset)
      bnd_ff <= BND_LAST)
      else $error("boundary match count out of range");

endmodule

/* design/mjdf_output_reg.sv */
// -----------------------------------------------------------------------------
// mjdf_output_reg
// Result register: holds one frame byte until the consumer takes it.
// -----------------------------------------------------------------------------
module mjdf_output_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  mjdf_pkg::result_type result,
   output logic                 advance,
   mjdf_rsp_if.source           rsp_chan
);
   import mjdf_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   assign advance = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = result.valid;
         byte_in  = result.frame_byte;
         last_in  = result.frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.frame_byte = byte_ff;
   assign rsp_chan.frame_last = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !result.valid)
      else $error("result produced while output register is stalled");

   a_load: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> valid_ff && byte_ff == $past(result.frame_byte))
      else $error("result not captured");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_chan.ready && !result.valid |=> !valid_ff)
      else $error("delivered result repeated");

endmodule

/* design/mjpeg_multipart_deframer.sv */
// -----------------------------------------------------------------------------
// mjpeg_multipart_deframer
// Extracts JPEG frames from MJPEG multipart bytes, one byte a cycle unless stalled.
// -----------------------------------------------------------------------------
//  channel   dir  payload                    transfer
//  req_chan  in   in_byte[7:0]               valid & ready
//  rsp_chan  out  frame_byte[7:0], frame_last valid & ready
//
//  one stream byte per cycle sustained while rsp_chan is not stalled; a taken
//  byte passes the input register, then the parser update into the result
//  register, and its frame byte, if any, shows on rsp_chan from there
//  reset (synchronous) empties both registers and starts hunting for a boundary
//  a stalled rsp_chan holds the parser; req_chan then takes at most one more byte
// -----------------------------------------------------------------------------
module mjpeg_multipart_deframer #(
   parameter int unsigned LEN_BITS = mjdf_pkg::LEN_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mjdf_req_if.sink   req_chan,
   mjdf_rsp_if.source rsp_chan
);
   import mjdf_pkg::*;

   item_type   item;
   result_type result;
   logic       advance;

   mjdf_input_reg u_input_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (advance),
      .item     (item)
   );

   mjdf_step #(
      .LEN_BITS (LEN_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .take   (advance),
      .result (result)
   );

   mjdf_output_reg u_output_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule
